// ===== src/cop_pkg.sv =====
// ----------------------------------------------------------------------------
// Coarse occupancy pool package
// Shared constants, types and helpers for the coarse occupancy max pool.
// ----------------------------------------------------------------------------
package cop_pkg;

    localparam int CELL_W       = 8;
    localparam int WINDOW       = 8;
    localparam int CHUNK_W      = CELL_W * WINDOW;
    localparam int COARSE_ROW_W = 9;
    localparam int CHUNK_COL_W  = 6;
    localparam int ROW_COUNT_W  = 4;
    localparam int WIDTH_CFG_W  = 7;
    localparam int HEIGHT_CFG_W = 10;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_INDEX_W  = 1;
    localparam int QUEUE_DEPTH  = 4;

    localparam int DEF_MAX_WIDTH_CELLS = 512;
    localparam int DEF_MAX_HEIGHT_ROWS = 512;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = WIDTH_CFG_W'(64);
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = HEIGHT_CFG_W'(512);

    localparam logic [ROW_COUNT_W-1:0] COUNT_SINGLE = ROW_COUNT_W'(1);
    localparam logic [ROW_COUNT_W-1:0] COUNT_FINAL  = ROW_COUNT_W'(WINDOW);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_WIDTH_CHUNKS = 1'b0,
        REG_MAP_HEIGHT_ROWS  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [WIDTH_CFG_W-1:0]  width_chunks;
        logic [HEIGHT_CFG_W-1:0] height_rows;
    } t_map_cfg;

    // One chunk update. Between front and back, chunk holds the horizontal
    // window maxima; after the back end it holds the coarse result.
    typedef struct packed {
        logic [CHUNK_W-1:0]      chunk;
        logic [COARSE_ROW_W-1:0] coarse_row;
        logic [CHUNK_COL_W-1:0]  chunk_column;
        logic [ROW_COUNT_W-1:0]  row_count;
        logic                    emit;
        logic                    last;
    } t_op;

    function automatic logic [CELL_W-1:0] byte_max8(input logic [CHUNK_W-1:0] v);
        logic [CELL_W-1:0] m;
        m = '0;
        for (int b = 0; b < WINDOW; b++) begin
            if (v[CELL_W*b +: CELL_W] > m) begin
                m = v[CELL_W*b +: CELL_W];
            end
        end
        return m;
    endfunction

endpackage

// ===== src/cop_queue.sv =====
// ----------------------------------------------------------------------------
// Coarse occupancy pool queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cop_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== src/cop_front.sv =====
// ----------------------------------------------------------------------------
// Coarse occupancy pool front end
// Accepts map words, tracks row and word cursors, and turns each word into
// zero, one or two chunk updates with their horizontal window maxima.
// ----------------------------------------------------------------------------
module cop_front #(
    parameter int MAX_WIDTH_CELLS = cop_pkg::DEF_MAX_WIDTH_CELLS,
    parameter int MAX_HEIGHT_ROWS = cop_pkg::DEF_MAX_HEIGHT_ROWS,
    parameter int ADDR_W          = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cop_pkg::t_map_cfg            i_cfg,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [cop_pkg::CHUNK_W-1:0]  i_cell_chunk,
    output logic                         o_push,
    output logic [ADDR_W-1:0]            o_push_addr,
    output cop_pkg::t_op                 o_push_op,
    input  logic                         i_q_full
);
    import cop_pkg::*;

    localparam int MAX_CHUNKS = MAX_WIDTH_CELLS / WINDOW;
    localparam int ROW_W      = $clog2(MAX_HEIGHT_ROWS);
    localparam int WCNT_W     = ((ADDR_W > WIDTH_CFG_W) ? ADDR_W : WIDTH_CFG_W) + 1;
    localparam int RCNT_W     = ((ROW_W > HEIGHT_CFG_W) ? ROW_W : HEIGHT_CFG_W) + 1;

    logic [CHUNK_W-1:0] r_prev;
    logic [ROW_W-1:0]   r_row;
    logic [ADDR_W-1:0]  r_word;
    logic               r_pend_valid;
    logic [ADDR_W-1:0]  r_pend_addr;
    t_op                r_pend_op;

    logic [WCNT_W-1:0]  w_eff, word_next;
    logic [RCNT_W-1:0]  h_eff, row_next;
    logic               accept, row_end, last_row, map_end, emit;
    logic [CHUNK_W-1:0] hmax_lo, hmax_hi;
    t_op                op_lo, op_hi;
    logic [ADDR_W-1:0]  addr_lo;

    function automatic logic [CHUNK_W-1:0] window_max(input logic [CHUNK_W-1:0] lo,
                                                      input logic [CHUNK_W-1:0] hi);
        logic [2*CHUNK_W-1:0] pair;
        logic [CHUNK_W-1:0]   res;
        pair = {hi, lo};
        res  = '0;
        for (int j = 0; j < WINDOW; j++) begin
            res[CELL_W*j +: CELL_W] = byte_max8(pair[CELL_W*j +: CHUNK_W]);
        end
        return res;
    endfunction

    always_comb begin
        if (i_cfg.width_chunks == '0) begin
            w_eff = WCNT_W'(1);
        end else if (WCNT_W'(i_cfg.width_chunks) > WCNT_W'(MAX_CHUNKS)) begin
            w_eff = WCNT_W'(MAX_CHUNKS);
        end else begin
            w_eff = WCNT_W'(i_cfg.width_chunks);
        end
        if (RCNT_W'(i_cfg.height_rows) < RCNT_W'(WINDOW)) begin
            h_eff = RCNT_W'(WINDOW);
        end else if (RCNT_W'(i_cfg.height_rows) > RCNT_W'(MAX_HEIGHT_ROWS)) begin
            h_eff = RCNT_W'(MAX_HEIGHT_ROWS);
        end else begin
            h_eff = RCNT_W'(i_cfg.height_rows);
        end
    end

    assign word_next = WCNT_W'(r_word) + WCNT_W'(1);
    assign row_next  = RCNT_W'(r_row) + RCNT_W'(1);
    assign row_end   = (word_next >= w_eff);
    assign last_row  = (row_next >= h_eff);
    assign map_end   = row_end && last_row;
    assign emit      = (r_row >= ROW_W'(WINDOW - 1));

    assign o_stall = r_pend_valid || i_q_full;
    assign accept  = i_valid && !o_stall;

    assign hmax_lo = window_max(r_prev, i_cell_chunk);
    assign hmax_hi = window_max(i_cell_chunk, '0);
    assign addr_lo = r_word - ADDR_W'(1);

    always_comb begin
        op_lo.chunk        = hmax_lo;
        op_lo.coarse_row   = COARSE_ROW_W'(r_row - ROW_W'(WINDOW - 1));
        op_lo.chunk_column = CHUNK_COL_W'(addr_lo);
        op_lo.row_count    = last_row ? COUNT_FINAL : COUNT_SINGLE;
        op_lo.emit         = emit;
        op_lo.last         = 1'b0;

        op_hi              = op_lo;
        op_hi.chunk        = hmax_hi;
        op_hi.chunk_column = CHUNK_COL_W'(r_word);
        op_hi.last         = map_end;
    end

    // The pending update takes the queue first; new words wait behind it.
    always_comb begin
        o_push      = 1'b0;
        o_push_addr = addr_lo;
        o_push_op   = op_lo;
        if (r_pend_valid) begin
            o_push      = !i_q_full;
            o_push_addr = r_pend_addr;
            o_push_op   = r_pend_op;
        end else if (accept && (r_word != '0)) begin
            o_push = 1'b1;
        end else if (accept && row_end) begin
            o_push      = 1'b1;
            o_push_addr = r_word;
            o_push_op   = op_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_row        <= '0;
            r_word       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (r_pend_valid && !i_q_full) begin
                r_pend_valid <= 1'b0;
            end
            if (accept) begin
                r_prev <= i_cell_chunk;
                if (row_end) begin
                    r_word <= '0;
                    r_row  <= map_end ? '0 : ROW_W'(row_next);
                    if (r_word != '0) begin
                        r_pend_valid <= 1'b1;
                    end
                end else begin
                    r_word <= ADDR_W'(word_next);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_addr <= r_word;
            r_pend_op   <= op_hi;
        end
    end

endmodule

// ===== src/cop_back.sv =====
// ----------------------------------------------------------------------------
// Coarse occupancy pool back end
// Performs one read-modify-write of the column row-maxima memory per chunk
// update and forms the coarse chunk from the eight stored rows.
// ----------------------------------------------------------------------------
module cop_back #(
    parameter int MAX_WIDTH_CELLS = cop_pkg::DEF_MAX_WIDTH_CELLS,
    parameter int ADDR_W          = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  logic [ADDR_W-1:0] i_q_addr,
    input  cop_pkg::t_op      i_q_op,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output cop_pkg::t_op      o_op
);
    import cop_pkg::*;

    localparam int MAX_CHUNKS = MAX_WIDTH_CELLS / WINDOW;
    localparam int ROW_BITS   = WINDOW * CHUNK_W;

    logic [ROW_BITS-1:0] r_mem [MAX_CHUNKS];

    logic                r_a_valid;
    logic [ADDR_W-1:0]   r_a_addr;
    t_op                 r_a_op;
    logic [ROW_BITS-1:0] r_rd_data;
    logic                r_hit;
    logic [ROW_BITS-1:0] r_fwd;
    logic                r_out_valid;
    t_op                 r_out_op;

    logic                out_free, a_move, load;
    logic [ROW_BITS-1:0] col_old, col_new;
    logic [CHUNK_W-1:0]  coarse;
    t_op                 a_result;

    assign out_free = !r_out_valid || !i_stall;
    assign a_move   = r_a_valid && (!r_a_op.emit || out_free);
    assign load     = i_q_valid && (!r_a_valid || a_move);
    assign o_q_pop  = load;

    // A column read in the same cycle as the write of the same column sees the
    // old contents, so the written value is forwarded instead.
    assign col_old = r_hit ? r_fwd : r_rd_data;

    always_comb begin
        for (int j = 0; j < WINDOW; j++) begin
            col_new[CHUNK_W*j +: CHUNK_W] = {col_old[CHUNK_W*j +: CHUNK_W-CELL_W],
                                             r_a_op.chunk[CELL_W*j +: CELL_W]};
            coarse[CELL_W*j +: CELL_W]    = byte_max8(col_new[CHUNK_W*j +: CHUNK_W]);
        end
        a_result       = r_a_op;
        a_result.chunk = coarse;
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_mem[r_a_addr] <= col_new;
        end
        if (load) begin
            r_rd_data <= r_mem[i_q_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_a_valid <= 1'b1;
                r_hit     <= a_move && (i_q_addr == r_a_addr);
            end else if (a_move) begin
                r_a_valid <= 1'b0;
                r_hit     <= 1'b0;
            end
            if (a_move && r_a_op.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a_addr <= i_q_addr;
            r_a_op   <= i_q_op;
            r_fwd    <= col_new;
        end
        if (a_move && r_a_op.emit) begin
            r_out_op <= a_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_op    = r_out_op;

endmodule

// ===== src/coarse_occupancy_max_pool.sv =====
// ----------------------------------------------------------------------------
// Coarse occupancy max pool
// 8x8 sliding-window maximum over a raster occupancy map, one coarse chunk
// per eight-cell word.
// ----------------------------------------------------------------------------
// The block takes one 64-bit map word per cycle while o_stall is low. A word
// ending a row that is not its row's first word yields two chunk updates and
// stalls the input while the second is queued; the back end performs one
// read-modify-write of the column row-maxima memory per update. With the
// output free, a result passes the queue, the read stage and the output
// register after its word is accepted. The row-maxima memory is not cleared
// after reset: the first seven rows of each map fill it before any result
// reads it. Configuration is to be written through the plain write port only
// while the block is idle; the block itself does not enforce this.
module coarse_occupancy_max_pool #(
    parameter int MAX_WIDTH_CELLS = cop_pkg::DEF_MAX_WIDTH_CELLS,
    parameter int MAX_HEIGHT_ROWS = cop_pkg::DEF_MAX_HEIGHT_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cop_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [cop_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [cop_pkg::CHUNK_W-1:0]      i_cell_chunk,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [cop_pkg::CHUNK_W-1:0]      o_coarse_chunk,
    output logic [cop_pkg::COARSE_ROW_W-1:0] o_coarse_row,
    output logic [cop_pkg::CHUNK_COL_W-1:0]  o_chunk_column,
    output logic [cop_pkg::ROW_COUNT_W-1:0]  o_row_count,
    output logic                             o_last
);
    import cop_pkg::*;

    localparam int MAX_CHUNKS = MAX_WIDTH_CELLS / WINDOW;
    localparam int ADDR_W     = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int OP_W       = $bits(t_op);
    localparam int Q_W        = ADDR_W + OP_W;

    t_map_cfg          r_cfg;
    logic              push, q_full, q_valid, q_pop;
    logic [ADDR_W-1:0] push_addr, q_addr;
    t_op               push_op, q_op, out_op;
    logic [Q_W-1:0]    q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_chunks <= WIDTH_RESET;
            r_cfg.height_rows  <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                REG_MAP_WIDTH_CHUNKS: r_cfg.width_chunks <= i_cfg_data[WIDTH_CFG_W-1:0];
                REG_MAP_HEIGHT_ROWS:  r_cfg.height_rows  <= i_cfg_data[HEIGHT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    cop_front #(
        .MAX_WIDTH_CELLS(MAX_WIDTH_CELLS),
        .MAX_HEIGHT_ROWS(MAX_HEIGHT_ROWS),
        .ADDR_W         (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cell_chunk(i_cell_chunk),
        .o_push      (push),
        .o_push_addr (push_addr),
        .o_push_op   (push_op),
        .i_q_full    (q_full)
    );

    cop_queue #(
        .DATA_W(Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data({push_addr, push_op}),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_data     (q_data)
    );

    assign q_addr = q_data[Q_W-1 -: ADDR_W];
    assign q_op   = q_data[OP_W-1:0];

    cop_back #(
        .MAX_WIDTH_CELLS(MAX_WIDTH_CELLS),
        .ADDR_W         (ADDR_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_addr (q_addr),
        .i_q_op   (q_op),
        .o_q_pop  (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_op     (out_op)
    );

    assign o_coarse_chunk = out_op.chunk;
    assign o_coarse_row   = out_op.coarse_row;
    assign o_chunk_column = out_op.chunk_column;
    assign o_row_count    = out_op.row_count;
    assign o_last         = out_op.last;

endmodule

// ===== bench/coarse_occupancy_max_pool_tb.sv =====
// ----------------------------------------------------------------------------
// Coarse occupancy max pool testbench
// Streams raster map words into the block, mirrors its 8x8 sliding-window
// maximum in a scoreboard and compares every coarse chunk field by field.
// Both sides idle and stall at random, map sizes change between maps and,
// where legal, in the middle of one.
// ----------------------------------------------------------------------------
module coarse_occupancy_max_pool_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cop_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int MAX_CHUNKS  = DEF_MAX_WIDTH_CELLS / WINDOW;
    localparam int MAX_ROWS    = DEF_MAX_HEIGHT_ROWS;
    localparam int SETTLE      = 12;
    localparam int LONG_HOLD   = 150;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct packed {
        logic [CHUNK_W-1:0]      chunk;
        logic [COARSE_ROW_W-1:0] coarse_row;
        logic [CHUNK_COL_W-1:0]  chunk_column;
        logic [ROW_COUNT_W-1:0]  row_count;
        logic                    last;
    } t_coarse_result;

    class coarse_map_scoreboard;
        logic [WIDTH_CFG_W-1:0]  width_reg;
        logic [HEIGHT_CFG_W-1:0] height_reg;
        logic [CHUNK_W-1:0]      prev_word;
        logic [CHUNK_W-1:0]      row_maxima [DEF_MAX_WIDTH_CELLS];
        int                      word_cur;
        int                      row_cur;
        t_coarse_result          coarse_due [$];
        int                      failures;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            prev_word  = '0;
            word_cur   = 0;
            row_cur    = 0;
            failures   = 0;
            foreach (row_maxima[i]) begin
                row_maxima[i] = '0;
            end
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MAP_WIDTH_CHUNKS) begin
                width_reg = data[WIDTH_CFG_W-1:0];
            end else begin
                height_reg = data[HEIGHT_CFG_W-1:0];
            end
        endfunction

        function int eff_width();
            if (width_reg < 1) begin
                return 1;
            end
            return (width_reg > MAX_CHUNKS) ? MAX_CHUNKS : int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg < WINDOW) begin
                return WINDOW;
            end
            return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
        endfunction

        function int words_to_map_end();
            int w;
            int h;
            int rows_after;
            w = eff_width();
            h = eff_height();
            rows_after = (row_cur + 1 >= h) ? 0 : h - 1 - row_cur;
            return rows_after * w + ((word_cur + 1 >= w) ? 1 : w - word_cur);
        endfunction

        // Shifts the horizontal maxima of word k into the per-cell history and
        // returns the vertical maxima over the last eight rows.
        function logic [CHUNK_W-1:0] pool_window(int k, logic [CHUNK_W-1:0] lo,
                                                 logic [CHUNK_W-1:0] hi);
            logic [2*CHUNK_W-1:0] span;
            logic [CHUNK_W-1:0]   coarse;
            logic [CELL_W-1:0]    hmax;
            logic [CELL_W-1:0]    vmax;
            int                   cell_idx;
            span = {hi, lo};
            coarse = '0;
            for (int j = 0; j < WINDOW; j++) begin
                hmax = '0;
                for (int t = 0; t < WINDOW; t++) begin
                    if (span[CELL_W*(j+t) +: CELL_W] > hmax) begin
                        hmax = span[CELL_W*(j+t) +: CELL_W];
                    end
                end
                cell_idx = (k * WINDOW + j) % DEF_MAX_WIDTH_CELLS;
                row_maxima[cell_idx] = {row_maxima[cell_idx][CHUNK_W-CELL_W-1:0], hmax};
                vmax = '0;
                for (int t = 0; t < WINDOW; t++) begin
                    if (row_maxima[cell_idx][CELL_W*t +: CELL_W] > vmax) begin
                        vmax = row_maxima[cell_idx][CELL_W*t +: CELL_W];
                    end
                end
                coarse[CELL_W*j +: CELL_W] = vmax;
            end
            return coarse;
        endfunction

        function void take_map_word(logic [CHUNK_W-1:0] word);
            int             w;
            int             h;
            int             k;
            int             y;
            bit             row_end;
            bit             map_end;
            bit             emitting;
            t_coarse_result r;
            w = eff_width();
            h = eff_height();
            k = word_cur;
            y = row_cur;
            row_end  = (k + 1 >= w);
            map_end  = row_end && (y + 1 >= h);
            emitting = (y >= WINDOW - 1);
            r.coarse_row = COARSE_ROW_W'(y - (WINDOW - 1));
            r.row_count  = (y + 1 >= h) ? COUNT_FINAL : COUNT_SINGLE;
            r.last       = 1'b0;
            // The previous word is complete once its right neighbor is here.
            if (k > 0) begin
                r.chunk        = pool_window(k - 1, prev_word, word);
                r.chunk_column = CHUNK_COL_W'(k - 1);
                if (emitting) begin
                    coarse_due.push_back(r);
                end
            end
            // At a row end the current word is pooled against zero cells.
            if (row_end) begin
                r.chunk        = pool_window(k, word, '0);
                r.chunk_column = CHUNK_COL_W'(k);
                r.last         = map_end;
                if (emitting) begin
                    coarse_due.push_back(r);
                end
            end
            prev_word = word;
            if (row_end) begin
                word_cur = 0;
                row_cur  = map_end ? 0 : (y + 1) % (1 << COARSE_ROW_W);
            end else begin
                word_cur = (k + 1) % (1 << CHUNK_COL_W);
            end
        endfunction

        function void match_coarse(t_coarse_result seen);
            t_coarse_result want;
            if (coarse_due.size() == 0) begin
                $error("unexpected coarse chunk %h at row %0d column %0d",
                       seen.chunk, seen.coarse_row, seen.chunk_column);
                failures++;
                return;
            end
            want = coarse_due.pop_front();
            if (seen.chunk !== want.chunk) begin
                $error("coarse_chunk: expected %h, got %h", want.chunk, seen.chunk);
                failures++;
            end
            if (seen.coarse_row !== want.coarse_row) begin
                $error("coarse_row: expected %0d, got %0d", want.coarse_row, seen.coarse_row);
                failures++;
            end
            if (seen.chunk_column !== want.chunk_column) begin
                $error("chunk_column: expected %0d, got %0d",
                       want.chunk_column, seen.chunk_column);
                failures++;
            end
            if (seen.row_count !== want.row_count) begin
                $error("row_count: expected %0d, got %0d", want.row_count, seen.row_count);
                failures++;
            end
            if (seen.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, seen.last);
                failures++;
            end
        endfunction
    endclass

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data   = '0;
    logic                    i_valid      = 1'b0;
    logic                    o_stall;
    logic [CHUNK_W-1:0]      i_cell_chunk = '0;
    logic                    o_valid;
    logic                    i_stall      = 1'b0;
    logic [CHUNK_W-1:0]      o_coarse_chunk;
    logic [COARSE_ROW_W-1:0] o_coarse_row;
    logic [CHUNK_COL_W-1:0]  o_chunk_column;
    logic [ROW_COUNT_W-1:0]  o_row_count;
    logic                    o_last;

    coarse_map_scoreboard sb = new();
    bit                   fast_send = 1'b0;
    bit                   fast_recv = 1'b0;
    bit                   long_hold = 1'b0;
    int                   idle_cycles = 0;
    t_coarse_result       seen;

    coarse_occupancy_max_pool dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cell_chunk   (i_cell_chunk),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_coarse_chunk (o_coarse_chunk),
        .o_coarse_row   (o_coarse_row),
        .o_chunk_column (o_chunk_column),
        .o_row_count    (o_row_count),
        .o_last         (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mostly sparse rows with low values, so that the maxima actually vary.
    function automatic logic [CHUNK_W-1:0] random_cells();
        logic [CHUNK_W-1:0] v;
        if ($urandom_range(0, 7) == 0) begin
            return {$urandom, $urandom};
        end
        for (int b = 0; b < WINDOW; b++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: v[CELL_W*b +: CELL_W] = '0;
                6, 7, 8:          v[CELL_W*b +: CELL_W] = CELL_W'($urandom_range(1, 40));
                default:          v[CELL_W*b +: CELL_W] = CELL_W'($urandom_range(0, 255));
            endcase
        end
        return v;
    endfunction

    // Valid is left high after a transaction so that a gapless next word
    // does not lower and raise it in the same step.
    task automatic send_word(input logic [CHUNK_W-1:0] word);
        int gap;
        gap = fast_send ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cell_chunk <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_map_word(word);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.coarse_due.size() > 0) @(posedge i_clk);
        // A word of an early row gives no result but may still be in flight.
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        sb.write_reg(idx, CFG_DATA_W'(value));
    endtask

    task automatic configure(input bit set_width, input int width_val,
                             input bit set_height, input int height_val);
        if (set_width) begin
            write_reg(REG_MAP_WIDTH_CHUNKS, width_val);
        end
        if (set_height) begin
            write_reg(REG_MAP_HEIGHT_ROWS, height_val);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Inside a map the width may only shrink: wider columns would hold no
    // history for the current map.
    task automatic reconfigure();
        bit at_start;
        int wv;
        int hv;
        int sel;
        at_start = (sb.word_cur == 0 && sb.row_cur == 0);
        case ($urandom_range(0, 9))
            0:       wv = 0;
            1:       wv = at_start ? MAX_CHUNKS : $urandom_range(1, sb.eff_width());
            2:       wv = at_start ? $urandom_range(MAX_CHUNKS + 1, 127) : 1;
            3, 4:    wv = at_start ? $urandom_range(5, 16) : $urandom_range(1, sb.eff_width());
            default: wv = at_start ? $urandom_range(1, 4) : $urandom_range(1, sb.eff_width());
        endcase
        case ($urandom_range(0, 9))
            0:       hv = $urandom_range(0, WINDOW - 1);
            1:       hv = MAX_ROWS;
            2:       hv = $urandom_range(MAX_ROWS + 1, 1023);
            3:       hv = $urandom_range(13, 40);
            default: hv = $urandom_range(WINDOW, 12);
        endcase
        sel = $urandom_range(0, 2);
        configure(sel != 1, wv, sel != 0, hv);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen.chunk        = o_coarse_chunk;
            seen.coarse_row   = o_coarse_row;
            seen.chunk_column = o_chunk_column;
            seen.row_count    = o_row_count;
            seen.last         = o_last;
            sb.match_coarse(seen);
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("coarse_occupancy_max_pool_tb failed");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int hold;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = fast_recv ? 0 : $urandom_range(0, 17);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if ($urandom_range(0, 29) == 0) begin
                fast_recv = !fast_recv;
            end
        end
    end

    initial begin : stimulus
        logic [CHUNK_W-1:0] directed_words [24];
        int                 random_items;
        int                 count;
        // Three words per row over eight rows; only the last row gives results.
        directed_words = '{
            64'h0000000000000000, 64'h0000000000000080, 64'h0000000000000000,
            64'h00000000000000FF, 64'hFF00000000000000, 64'h0000000080000000,
            64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 64'h0102040810204080,
            64'h7F7F7F7F7F7F7F7F, 64'h8080808080808080, 64'h0000000000000000,
            64'h0000000000000001, 64'h0100000000000000, 64'h00FF000000000000,
            64'h0000000000000000, 64'h0000000000000000, 64'hFE00000000000000,
            64'h0000000000FF0000, 64'h0000FF0000000000, 64'h000000FF00000000,
            64'h1122334455667788, 64'h8877665544332211, 64'hFFFFFFFFFFFFFFFF
        };
        random_items = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(1'b1, 3, 1'b1, WINDOW);
        foreach (directed_words[n]) begin
            send_word(directed_words[n]);
        end
        drain();

        // A zero width acts as one word and an oversized height as the
        // maximum. The receiver holds off for a long stretch in the middle
        // so that the block backs up and stalls its input.
        configure(1'b1, 0, 1'b1, 1023);
        fast_send = 1'b1;
        for (int n = 0; n < MAX_ROWS; n++) begin
            if (n == 100) begin
                long_hold = 1'b1;
            end
            send_word(random_cells());
        end
        drain();

        // An oversized width acts as the maximum and a tiny height as eight.
        // One full-width row ends at the maximum width; the map then narrows
        // to one word per row and runs to its end.
        fast_send = 1'b0;
        configure(1'b1, 127, 1'b1, 3);
        repeat (MAX_CHUNKS) send_word(random_cells());
        drain();
        configure(1'b1, 1, 1'b0, 0);
        repeat (WINDOW - 1) send_word(random_cells());
        drain();

        // Start the widest and tallest map; the random phases cut it short.
        configure(1'b1, MAX_CHUNKS, 1'b1, MAX_ROWS);
        repeat (30) send_word(random_cells());
        drain();

        while (random_items < 60) begin
            if ($urandom_range(0, 3) != 0) begin
                reconfigure();
            end
            fast_send = ($urandom_range(0, 3) == 0);
            count = sb.words_to_map_end();
            if (count > 60 || $urandom_range(0, 3) == 0) begin
                count = $urandom_range(1, (count > 40) ? 40 : count);
            end
            repeat (count) send_word(random_cells());
            random_items += count;
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("coarse_occupancy_max_pool_tb passed");
        end else begin
            $display("coarse_occupancy_max_pool_tb failed");
        end
        $finish;
    end

endmodule
